// ===== hw/rtl/drp_pkg.sv =====
`default_nettype none

package drp_pkg;

    // Option area size, counted from the magic cookie at its start
    localparam int AREA_BYTES_DEF = 312;

    // Byte positions within the message
    localparam int          OPTIONS_START  = 236;
    localparam logic [9:0]  POS_WALK_START = 10'd240;
    localparam logic [9:0]  POS_MAX        = 10'd1023;
    // A last byte at this position or later gives a length of at least 548
    localparam logic [9:0]  POS_LAST_MIN   = 10'd547;
    localparam logic [7:0]  POS_XID_WORD   = 8'd1;   // positions 4 to 7
    localparam logic [7:0]  POS_YIADDR_WORD = 8'd4;  // positions 16 to 19

    localparam logic [31:0] XID_RESET = 32'h1234_5678;

    // Option codes
    localparam logic [7:0] OPT_PAD       = 8'd0;
    localparam logic [7:0] OPT_SUBNET    = 8'd1;
    localparam logic [7:0] OPT_ROUTER    = 8'd3;
    localparam logic [7:0] OPT_DNS       = 8'd6;
    localparam logic [7:0] OPT_MSG_TYPE  = 8'd53;
    localparam logic [7:0] OPT_SERVER_ID = 8'd54;
    localparam logic [7:0] OPT_END       = 8'hFF;

    // Message types
    localparam logic [7:0] TYPE_OFFER = 8'd2;
    localparam logic [7:0] TYPE_ACK   = 8'd5;

    typedef enum logic [1:0] {
        ACT_NONE      = 2'd0,
        ACT_REQUEST   = 2'd1,
        ACT_CONFIGURE = 2'd2
    } t_action;

    typedef enum logic [1:0] {
        PH_CODE  = 2'd0,
        PH_LEN   = 2'd1,
        PH_VALUE = 2'd2
    } t_phase;

    // Control from the byte stage to the option walker
    typedef struct packed {
        logic step;    // a byte leaves the input register
        logic walk;    // the byte lies in the option area
        logic clear;   // the byte ends the message
    } t_walk_ctl;

    // Captured option values, including the current byte
    typedef struct packed {
        logic [7:0]  dhcp_type;
        logic [31:0] subnet;
        logic [31:0] router;
        logic [31:0] dns;
        logic [31:0] server;
    } t_opt_vals;

endpackage

`default_nettype wire

// ===== hw/rtl/drp_if.sv =====
`default_nettype none

// Byte request channel
interface drp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

// Parse result channel
interface drp_out_if;
    logic        valid;
    logic        ready;
    logic        accepted;
    logic [1:0]  action;
    logic [7:0]  message_type;
    logic [31:0] offered_ip;
    logic [31:0] subnet_mask;
    logic [31:0] router_ip;
    logic [31:0] dns_ip;
    logic [31:0] server_ip;

    modport source (
        output valid, output accepted, output action, output message_type,
        output offered_ip, output subnet_mask, output router_ip, output dns_ip,
        output server_ip, input ready
    );
    modport sink (
        input valid, input accepted, input action, input message_type,
        input offered_ip, input subnet_mask, input router_ip, input dns_ip,
        input server_ip, output ready
    );
endinterface

`default_nettype wire

// ===== hw/rtl/drp_option_walker.sv =====
`default_nettype none

module drp_option_walker (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire drp_pkg::t_walk_ctl  i_ctl,
    input  wire logic [7:0]          i_byte,
    input  wire logic [31:0]         i_reload,
    output drp_pkg::t_opt_vals       o_next
);

    drp_pkg::t_phase r_phase, n_phase;
    logic [7:0]  r_code, n_code;
    logic [7:0]  r_left, n_left;
    logic [7:0]  r_vidx, n_vidx;
    logic        r_end, n_end;
    logic [7:0]  r_type, n_type;
    logic [31:0] r_subnet, n_subnet;
    logic [31:0] r_router, n_router;
    logic [31:0] r_dns, n_dns;
    logic [31:0] r_server, n_server;
    logic        walk_go;

    // Replace one byte of a word, index 0 in bits 31..24
    function automatic logic [31:0] put_byte(input logic [31:0] w, input logic [1:0] idx,
                                             input logic [7:0] b);
        logic [31:0] r;
        r = w;
        case (idx)
            2'd0:    r[31:24] = b;
            2'd1:    r[23:16] = b;
            2'd2:    r[15:8]  = b;
            default: r[7:0]   = b;
        endcase
        return r;
    endfunction

    assign walk_go = i_ctl.walk && !r_end;

    // Next state of the TLV walk
    always_comb begin
        n_phase = r_phase;
        n_code  = r_code;
        n_left  = r_left;
        n_vidx  = r_vidx;
        n_end   = r_end;
        if (walk_go) begin
            case (r_phase)
                drp_pkg::PH_LEN: begin
                    n_left  = i_byte;
                    n_vidx  = 8'd0;
                    n_phase = (i_byte != 8'd0) ? drp_pkg::PH_VALUE : drp_pkg::PH_CODE;
                end
                drp_pkg::PH_VALUE: begin
                    if (r_vidx != 8'hFF) n_vidx = r_vidx + 8'd1;
                    if (r_left != 8'd0) n_left = r_left - 8'd1;
                    if (n_left == 8'd0) n_phase = drp_pkg::PH_CODE;
                end
                default: begin
                    n_phase = drp_pkg::PH_CODE;
                    if (i_byte == drp_pkg::OPT_END) begin
                        n_end = 1'b1;
                    end else if (i_byte != drp_pkg::OPT_PAD) begin
                        n_code  = i_byte;
                        n_phase = drp_pkg::PH_LEN;
                    end
                end
            endcase
        end
    end

    // Capture value bytes of the options of interest
    always_comb begin
        n_type   = r_type;
        n_subnet = r_subnet;
        n_router = r_router;
        n_dns    = r_dns;
        n_server = r_server;
        if (walk_go && r_phase == drp_pkg::PH_VALUE) begin
            if (r_code == drp_pkg::OPT_MSG_TYPE) begin
                if (r_vidx == 8'd0) n_type = i_byte;
            end else if (r_vidx < 8'd4) begin
                case (r_code)
                    drp_pkg::OPT_SUBNET:    n_subnet = put_byte(r_subnet, r_vidx[1:0], i_byte);
                    drp_pkg::OPT_ROUTER:    n_router = put_byte(r_router, r_vidx[1:0], i_byte);
                    drp_pkg::OPT_DNS:       n_dns    = put_byte(r_dns, r_vidx[1:0], i_byte);
                    drp_pkg::OPT_SERVER_ID: n_server = put_byte(r_server, r_vidx[1:0], i_byte);
                    default: ;
                endcase
            end
        end
    end

    assign o_next.dhcp_type = n_type;
    assign o_next.subnet    = n_subnet;
    assign o_next.router    = n_router;
    assign o_next.dns       = n_dns;
    assign o_next.server    = n_server;

    // Advance per byte; return to a fresh message after the last byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= drp_pkg::PH_CODE;
            r_code   <= 8'd0;
            r_left   <= 8'd0;
            r_vidx   <= 8'd0;
            r_end    <= 1'b0;
            r_type   <= 8'd0;
            r_subnet <= 32'd0;
            r_router <= 32'd0;
            r_dns    <= 32'd0;
            r_server <= 32'd0;
        end else if (i_ctl.step) begin
            if (i_ctl.clear) begin
                r_phase  <= drp_pkg::PH_CODE;
                r_code   <= 8'd0;
                r_left   <= 8'd0;
                r_vidx   <= 8'd0;
                r_end    <= 1'b0;
                r_type   <= 8'd0;
                r_subnet <= 32'd0;
                r_router <= 32'd0;
                r_dns    <= 32'd0;
                r_server <= i_reload;
            end else begin
                r_phase  <= n_phase;
                r_code   <= n_code;
                r_left   <= n_left;
                r_vidx   <= n_vidx;
                r_end    <= n_end;
                r_type   <= n_type;
                r_subnet <= n_subnet;
                r_router <= n_router;
                r_dns    <= n_dns;
                r_server <= n_server;
            end
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/dhcp_reply_parser.sv =====
// Channel   Dir   Handshake      Payload
// i_req     in    valid/ready    data_byte[7:0], last_byte
// o_res     out   valid/ready    accepted, action[1:0], message_type[7:0],
//                                offered_ip, subnet_mask, router_ip, dns_ip, server_ip
// i_cfg     in    write enable   i_cfg_wdata[31:0] (expected transaction id)
//
// One byte per cycle while the input is not stalled. An accepted byte waits in the
// input register; when it retires, the id check, address capture and option walk
// are applied and, for a last byte, the result register is loaded. Synchronous
// active-low reset clears the valid flags and message state and loads the default
// expected id; the input byte and result fields are not reset; no clearing pass.
// A waiting result stalls the input only when the next byte to retire is a
// last byte; other bytes keep flowing.
`default_nettype none

module dhcp_reply_parser #(
    parameter int OPTION_AREA_BYTES = drp_pkg::AREA_BYTES_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [31:0] i_cfg_wdata,
    drp_in_if.sink           i_req,
    drp_out_if.source        o_res
);

    localparam int          AREA_END   = drp_pkg::OPTIONS_START + OPTION_AREA_BYTES;
    localparam logic [10:0] AREA_END_W = 11'(AREA_END);

    logic [31:0]         r_exp_xid;
    logic                r_in_valid;
    logic [7:0]          r_in_byte;
    logic                r_in_last;
    logic [9:0]          r_pos, n_pos;
    logic                r_id_ok, n_id_ok;
    logic [31:0]         r_yiaddr, n_yiaddr;
    logic [31:0]         r_kept, n_kept;
    logic                r_out_valid;
    logic                r_out_acc;
    drp_pkg::t_action    r_out_act, n_act;
    logic [7:0]          r_out_type;
    logic [31:0]         r_out_yiaddr;
    logic [31:0]         r_out_subnet;
    logic [31:0]         r_out_router;
    logic [31:0]         r_out_dns;
    logic [31:0]         r_out_server;
    logic                adv;
    logic                msg_ok;
    logic [7:0]          xid_byte;
    logic                in_area;
    drp_pkg::t_walk_ctl  walk_ctl;
    drp_pkg::t_opt_vals  opt_next;

    // Retire the held byte unless it is a last byte facing a full result register that is not taken
    assign adv = r_in_valid && (!r_in_last || !r_out_valid || o_res.ready);
    assign i_req.ready = !r_in_valid || adv;

    // Hold the expected id
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_xid <= drp_pkg::XID_RESET;
        end else if (i_cfg_we) begin
            r_exp_xid <= i_cfg_wdata;
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_req.ready) begin
            r_in_valid <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_in_byte <= i_req.data_byte;
            r_in_last <= i_req.last_byte;
        end
    end

    // Id check, little-endian over positions 4 to 7
    assign xid_byte = 8'(r_exp_xid >> {r_pos[1:0], 3'b000});

    always_comb begin
        n_id_ok  = r_id_ok;
        n_yiaddr = r_yiaddr;
        if (r_pos[9:2] == drp_pkg::POS_XID_WORD && r_in_byte != xid_byte) begin
            n_id_ok = 1'b0;
        end
        if (r_pos[9:2] == drp_pkg::POS_YIADDR_WORD) begin
            n_yiaddr = {r_yiaddr[23:0], r_in_byte};
        end
        n_pos = (r_pos != drp_pkg::POS_MAX) ? r_pos + 10'd1 : r_pos;
    end

    // Walk options only inside the option area and below the position ceiling
    assign in_area = (r_pos >= drp_pkg::POS_WALK_START) && ({1'b0, r_pos} < AREA_END_W)
                  && (r_pos != drp_pkg::POS_MAX);

    assign walk_ctl.step  = adv;
    assign walk_ctl.walk  = in_area;
    assign walk_ctl.clear = r_in_last;

    drp_option_walker u_walker (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (walk_ctl),
        .i_byte   (r_in_byte),
        .i_reload (n_kept),
        .o_next   (opt_next)
    );

    // Decide acceptance and action at the last byte
    assign msg_ok = (r_pos >= drp_pkg::POS_LAST_MIN) && n_id_ok;
    assign n_kept = msg_ok ? opt_next.server : r_kept;

    always_comb begin
        n_act = drp_pkg::ACT_NONE;
        if (msg_ok) begin
            if (opt_next.dhcp_type == drp_pkg::TYPE_OFFER) begin
                n_act = drp_pkg::ACT_REQUEST;
            end else if (opt_next.dhcp_type == drp_pkg::TYPE_ACK) begin
                n_act = drp_pkg::ACT_CONFIGURE;
            end
        end
    end

    // Message state: advance per byte, clear after the last byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= 10'd0;
            r_id_ok  <= 1'b1;
            r_yiaddr <= 32'd0;
            r_kept   <= 32'd0;
        end else if (adv) begin
            if (r_in_last) begin
                r_pos    <= 10'd0;
                r_id_ok  <= 1'b1;
                r_yiaddr <= 32'd0;
                r_kept   <= n_kept;
            end else begin
                r_pos    <= n_pos;
                r_id_ok  <= n_id_ok;
                r_yiaddr <= n_yiaddr;
            end
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && r_in_last) begin
            r_out_acc    <= msg_ok;
            r_out_act    <= n_act;
            r_out_type   <= msg_ok ? opt_next.dhcp_type : 8'd0;
            r_out_yiaddr <= msg_ok ? n_yiaddr : 32'd0;
            r_out_subnet <= msg_ok ? opt_next.subnet : 32'd0;
            r_out_router <= msg_ok ? opt_next.router : 32'd0;
            r_out_dns    <= msg_ok ? opt_next.dns : 32'd0;
            r_out_server <= n_kept;
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.accepted     = r_out_acc;
    assign o_res.action       = r_out_act;
    assign o_res.message_type = r_out_type;
    assign o_res.offered_ip   = r_out_yiaddr;
    assign o_res.subnet_mask  = r_out_subnet;
    assign o_res.router_ip    = r_out_router;
    assign o_res.dns_ip       = r_out_dns;
    assign o_res.server_ip    = r_out_server;

`ifndef NO_ASSERTIONS
    a_action_needs_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && (o_res.action != drp_pkg::ACT_NONE) |-> o_res.accepted)
        else $error("action given for a rejected message");

    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && !o_res.accepted |->
            o_res.message_type == 8'd0 && o_res.offered_ip == 32'd0 &&
            o_res.subnet_mask == 32'd0 && o_res.router_ip == 32'd0 &&
            o_res.dns_ip == 32'd0)
        else $error("rejected result carries captured fields");

    a_reject_keeps_server: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && !o_res.accepted |-> o_res.server_ip == r_kept)
        else $error("server id changed by a rejected message");

    a_pos_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv && r_in_last |=> r_pos == 10'd0 && r_id_ok)
        else $error("message state not cleared after last byte");

    a_pos_advances: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv && !r_in_last |=> r_pos >= $past(r_pos))
        else $error("byte position went backward within a message");
`endif

endmodule

`default_nettype wire

// ===== sim/tb_dhcp_reply_parser.sv =====
`timescale 1ns / 100ps

module tb_dhcp_reply_parser;

    // One parse result as it leaves the block
    typedef struct packed {
        logic        accepted;
        logic [1:0]  action;
        logic [7:0]  message_type;
        logic [31:0] offered_ip;
        logic [31:0] subnet_mask;
        logic [31:0] router_ip;
        logic [31:0] dns_ip;
        logic [31:0] server_ip;
    } t_parse_result;

    // Reply parser prediction and result checking
    class reply_scoreboard;
        logic [31:0]      xid;
        logic [9:0]       pos;
        drp_pkg::t_phase  walk_phase;
        logic [7:0]       code;
        logic [7:0]       left;
        logic [7:0]       vidx;
        logic             id_ok;
        logic             end_seen;
        logic [7:0]       mtype;
        logic [31:0]      yiaddr;
        logic [31:0]      subnet;
        logic [31:0]      router;
        logic [31:0]      dns;
        logic [31:0]      server_new;
        logic [31:0]      server_kept;
        t_parse_result    parsed_replies[$];
        int               walk_limit;
        int               errors;
        int               bytes_seen;
        int               replies_seen;
        int               accepted_seen;

        function new();
            walk_limit    = drp_pkg::OPTIONS_START + drp_pkg::AREA_BYTES_DEF;
            xid           = drp_pkg::XID_RESET;
            server_kept   = '0;
            errors        = 0;
            bytes_seen    = 0;
            replies_seen  = 0;
            accepted_seen = 0;
            clear_message();
        endfunction

        function void clear_message();
            pos        = '0;
            walk_phase = drp_pkg::PH_CODE;
            code       = '0;
            left       = '0;
            vidx       = '0;
            id_ok      = 1'b1;
            end_seen   = 1'b0;
            mtype      = '0;
            yiaddr     = '0;
            subnet     = '0;
            router     = '0;
            dns        = '0;
            server_new = server_kept;
        endfunction

        function logic [31:0] set_octet(logic [31:0] word, int idx, logic [7:0] b);
            word[31 - 8 * idx -: 8] = b;
            return word;
        endfunction

        // Store an option value byte; type takes its first byte, others four
        function void capture(logic [7:0] b);
            if (code == drp_pkg::OPT_MSG_TYPE) begin
                if (vidx == 0) mtype = b;
            end else if (vidx < 4) begin
                case (code)
                    drp_pkg::OPT_SUBNET:    subnet     = set_octet(subnet, vidx, b);
                    drp_pkg::OPT_ROUTER:    router     = set_octet(router, vidx, b);
                    drp_pkg::OPT_DNS:       dns        = set_octet(dns, vidx, b);
                    drp_pkg::OPT_SERVER_ID: server_new = set_octet(server_new, vidx, b);
                    default: ;
                endcase
            end
        endfunction

        // Advance the option TLV walker by one byte
        function void walk(logic [7:0] b);
            case (walk_phase)
                drp_pkg::PH_LEN: begin
                    left = b;
                    vidx = '0;
                    if (b != 0) walk_phase = drp_pkg::PH_VALUE;
                    else walk_phase = drp_pkg::PH_CODE;
                end
                drp_pkg::PH_VALUE: begin
                    capture(b);
                    if (vidx < 255) vidx++;
                    if (left > 0) left--;
                    if (left == 0) walk_phase = drp_pkg::PH_CODE;
                end
                default: begin
                    walk_phase = drp_pkg::PH_CODE;
                    if (b == drp_pkg::OPT_END) begin
                        end_seen = 1'b1;
                    end else if (b != drp_pkg::OPT_PAD) begin
                        code       = b;
                        walk_phase = drp_pkg::PH_LEN;
                    end
                end
            endcase
        endfunction

        // Note an accepted byte request; a last byte yields one expected result
        function void note_byte(logic [7:0] b, logic last);
            int            pi;
            logic          ok;
            t_parse_result r;
            pi = pos;
            bytes_seen++;
            if (pi >= 4 && pi <= 7) begin
                if (b != xid[8 * (pi - 4) +: 8]) id_ok = 1'b0;
            end
            if (pi >= 16 && pi <= 19) yiaddr = {yiaddr[23:0], b};
            if (pi >= drp_pkg::POS_WALK_START && pi < walk_limit && pi < drp_pkg::POS_MAX
                && !end_seen)
                walk(b);
            if (pi < drp_pkg::POS_MAX) pos = pos + 10'd1;
            if (!last) return;

            ok       = (pi >= drp_pkg::POS_LAST_MIN) && id_ok;
            r.action = drp_pkg::ACT_NONE;
            if (ok) begin
                server_kept = server_new;
                if (mtype == drp_pkg::TYPE_OFFER) r.action = drp_pkg::ACT_REQUEST;
                else if (mtype == drp_pkg::TYPE_ACK) r.action = drp_pkg::ACT_CONFIGURE;
            end
            r.accepted     = ok;
            r.message_type = ok ? mtype : 8'h00;
            r.offered_ip   = ok ? yiaddr : 32'h0;
            r.subnet_mask  = ok ? subnet : 32'h0;
            r.router_ip    = ok ? router : 32'h0;
            r.dns_ip       = ok ? dns : 32'h0;
            r.server_ip    = server_kept;
            parsed_replies.push_back(r);
            clear_message();
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                errors++;
                $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            end
        endfunction

        // Check one result against the oldest expectation
        function void check_result(t_parse_result got);
            t_parse_result want;
            if (parsed_replies.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none, actual %h", $time, got);
                return;
            end
            want = parsed_replies.pop_front();
            replies_seen++;
            if (want.accepted) accepted_seen++;
            compare_field("accepted", want.accepted, got.accepted);
            compare_field("action", want.action, got.action);
            compare_field("message_type", want.message_type, got.message_type);
            compare_field("offered_ip", want.offered_ip, got.offered_ip);
            compare_field("subnet_mask", want.subnet_mask, got.subnet_mask);
            compare_field("router_ip", want.router_ip, got.router_ip);
            compare_field("dns_ip", want.dns_ip, got.dns_ip);
            compare_field("server_ip", want.server_ip, got.server_ip);
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [31:0] i_cfg_wdata;

    drp_in_if  req_if();
    drp_out_if res_if();

    reply_scoreboard sb = new();

    int   send_idle_pct;
    int   recv_stall_pct;
    bit   hold_request;
    int   hold_left;
    int   input_stalls;
    logic [7:0] msg_q[$];

    dhcp_reply_parser #(
        .OPTION_AREA_BYTES(drp_pkg::AREA_BYTES_DEF)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_req      (req_if),
        .o_res      (res_if)
    );

    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    // Message building
    function automatic void begin_reply(input logic [31:0] xid, input logic [31:0] yiaddr);
        msg_q = {};
        for (int i = 0; i < drp_pkg::OPTIONS_START; i++) msg_q.push_back(8'($urandom));
        for (int i = 0; i < 4; i++) begin
            msg_q[4 + i]  = xid[8 * i +: 8];
            msg_q[16 + i] = yiaddr[31 - 8 * i -: 8];
        end
        msg_q.push_back(8'd99);
        msg_q.push_back(8'd130);
        msg_q.push_back(8'd83);
        msg_q.push_back(8'd99);
    endfunction

    function automatic void add_option(input logic [7:0] opt, input int len,
                                       input logic [31:0] value);
        msg_q.push_back(opt);
        msg_q.push_back(8'(len));
        for (int i = 0; i < len; i++)
            msg_q.push_back((i < 4) ? value[31 - 8 * i -: 8] : 8'($urandom));
    endfunction

    function automatic void add_fill(input int n, input logic [7:0] v);
        for (int i = 0; i < n; i++) msg_q.push_back(v);
    endfunction

    function automatic void fit_length(input int len);
        while (msg_q.size() < len) msg_q.push_back(8'($urandom));
        while (msg_q.size() > len) void'(msg_q.pop_back());
    endfunction

    // Offer one byte request and hold it until taken
    task automatic push_byte(input logic [7:0] b, input logic last);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_if.valid     <= 1'b1;
        req_if.data_byte <= b;
        req_if.last_byte <= last;
        @(posedge i_clk);
        while (!req_if.ready) begin
            input_stalls++;
            @(posedge i_clk);
        end
        sb.note_byte(b, last);
    endtask

    task automatic send_reply();
        for (int i = 0; i < msg_q.size(); i++) push_byte(msg_q[i], i == msg_q.size() - 1);
    endtask

    // Drop valid and hold until every expected result is in
    task automatic wait_replies();
        req_if.valid <= 1'b0;
        while (sb.parsed_replies.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_xid(input logic [31:0] v);
        wait_replies();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        sb.xid = v;
    endtask

    // Result side: check taken results, then pick ready for the next cycle
    initial begin
        t_parse_result got;
        hold_left    = 0;
        res_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && res_if.valid && res_if.ready) begin
                got.accepted     = res_if.accepted;
                got.action       = res_if.action;
                got.message_type = res_if.message_type;
                got.offered_ip   = res_if.offered_ip;
                got.subnet_mask  = res_if.subnet_mask;
                got.router_ip    = res_if.router_ip;
                got.dns_ip       = res_if.dns_ip;
                got.server_ip    = res_if.server_ip;
                sb.check_result(got);
            end
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left    = 300;
            end
            if (hold_left > 0) begin
                hold_left--;
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= !(recv_stall_pct != 0 && $urandom_range(99) < recv_stall_pct);
            end
        end
    end

    initial begin
        logic [31:0] phase_xid[4];
        int          send_pct[4];
        int          recv_pct[4];

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_request   = 1'b0;
        input_stalls   = 0;
        i_rst_n          <= 1'b0;
        i_cfg_we         <= 1'b0;
        i_cfg_wdata      <= '0;
        req_if.valid     <= 1'b0;
        req_if.data_byte <= '0;
        req_if.last_byte <= 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: one-byte message, far too short
        msg_q = {8'hFF};
        send_reply();

        // Minimal accepted offer: pads, unknown code, empty type, repeated and
        // over/under-length options, every captured option
        begin_reply(drp_pkg::XID_RESET, 32'hC0A8_0164);
        add_fill(2, drp_pkg::OPT_PAD);
        add_option(8'd99, 3, $urandom);
        add_option(drp_pkg::OPT_MSG_TYPE, 0, 32'h0);
        add_option(drp_pkg::OPT_MSG_TYPE, 1, {drp_pkg::TYPE_OFFER, 24'h0});
        add_option(drp_pkg::OPT_SUBNET, 4, 32'hFFFF_FF00);
        add_option(drp_pkg::OPT_SUBNET, 2, 32'hAABB_0000);
        add_option(drp_pkg::OPT_ROUTER, 6, 32'h0102_0304);
        add_option(drp_pkg::OPT_DNS, 2, 32'hCAFE_0000);
        add_option(drp_pkg::OPT_SERVER_ID, 4, 32'hC0A8_0001);
        msg_q.push_back(drp_pkg::OPT_END);
        fit_length(548);
        send_reply();

        // Receiver holds off while short messages keep coming
        wait_replies();
        hold_request = 1'b1;
        for (int i = 0; i < 20; i++) begin
            msg_q = {};
            fit_length($urandom_range(1, 2));
            send_reply();
        end
        wait_replies();

        // Random phases, each under its own id and idling mix
        phase_xid = '{32'h0000_0000, 32'hFFFF_FFFF, $urandom, $urandom};
        send_pct  = '{0, 68, 0, 10};
        recv_pct  = '{0, 0, 68, 10};
        for (int ph = 0; ph < 4; ph++) begin
            write_xid(phase_xid[ph]);
            send_idle_pct  = send_pct[ph];
            recv_stall_pct = recv_pct[ph];
            for (int m = 0; m < 4; m++) begin
                begin_reply(($urandom_range(3) == 0) ? 32'($urandom) : sb.xid, $urandom);
                fit_length($urandom_range(1, 14));
                send_reply();
            end
            if (ph == 1) wait_replies();
        end

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        wait_replies();
        repeat (8) @(posedge i_clk);

        $display("Run covered %0d bytes and %0d replies (%0d accepted) over four id settings,",
                 sb.bytes_seen, sb.replies_seen, sb.accepted_seen);
        $display("with %0d cycles of input back-pressure and %0d failures.",
                 input_stalls, sb.errors);
        if (sb.errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // Give up on a hung run
    initial begin
        #5_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/drp_pkg.sv
hw/rtl/drp_if.sv
hw/rtl/drp_option_walker.sv
hw/rtl/dhcp_reply_parser.sv
sim/tb_dhcp_reply_parser.sv
